// File: hdl/vml_pkg.sv
// ----------------------------------------------------------------------------
// vml_pkg: shared types and constants for the von Mangoldt block
// Widths, the ln 2 constant, controller states and the command/status
// structs that join the controller and the datapath.
// ----------------------------------------------------------------------------
`default_nettype none
package vml_pkg;
    localparam int N_BITS    = 16;
    localparam int LOG_W     = 21;
    localparam int MW        = 64;             // log mantissa width (Q62)
    localparam int FRAC_BITS = 48;
    localparam int K_W       = $clog2(N_BITS);
    localparam int IT_W      = $clog2(FRAC_BITS);
    localparam logic [MW-1:0] LN2_Q60 = 64'h0B17217F7D1CF79B;

    typedef enum logic [12:0] {
        S_IDLE  = 13'b0000000000001,
        S_CHK   = 13'b0000000000010,
        S_TDIV  = 13'b0000000000100,
        S_RDIV  = 13'b0000000001000,
        S_RWAIT = 13'b0000000010000,
        S_NORM  = 13'b0000000100000,
        S_SQ    = 13'b0000001000000,
        S_SQW   = 13'b0000010000000,
        S_KMUL  = 13'b0000100000000,
        S_KW    = 13'b0001000000000,
        S_FMUL  = 13'b0010000000000,
        S_FW    = 13'b0100000000000,
        S_DONE  = 13'b1000000000000
    } t_state;

    typedef struct packed {
        logic load;        // latch n, d = 2, base = 0
        logic div_trial;   // start n / d
        logic div_rest;    // start rest / p, rest = n on first
        logic rest_init;   // rest = n
        logic set_p_n;     // p = n
        logic set_p_d;     // p = d
        logic inc_d;
        logic rest_upd;    // rest = quotient
        logic norm_init;   // mantissa from p
        logic norm_step;
        logic mul_sq;
        logic sq_upd;
        logic mul_k;
        logic t1_upd;
        logic mul_f;
        logic t2_upd;
        logic finish;      // write result register
        logic pp;          // prime power flag for finish
    } t_cmd;

    typedef struct packed {
        logic n_le1;
        logic sq_gt_n;
        logic div_done;
        logic rem_zero;
        logic quot_one;
        logic m_norm;
        logic mul_done;
    } t_sts;
endpackage
`default_nettype wire

// File: hdl/vml_if.sv
// ----------------------------------------------------------------------------
// vml_in_if / vml_out_if: valid/ready channels of the von Mangoldt block
// A beat moves when valid and ready are both high at a rising edge.
// ----------------------------------------------------------------------------
`default_nettype none
interface vml_in_if;
    logic                        valid;
    logic                        ready;
    logic [vml_pkg::N_BITS-1:0]  n;
    modport source (output valid, output n, input ready);
    modport sink   (input valid, input n, output ready);
endinterface

interface vml_out_if;
    logic                        valid;
    logic                        ready;
    logic [15:0]                 base;
    logic                        is_prime_power;
    logic [vml_pkg::LOG_W-1:0]   log_value;
    modport source (output valid, output base, output is_prime_power,
                    output log_value, input ready);
    modport sink   (input valid, input base, input is_prime_power,
                    input log_value, output ready);
endinterface
`default_nettype wire

// File: hdl/vml_dp.sv
// ----------------------------------------------------------------------------
// vml_dp: datapath of the von Mangoldt block
// Iterative divider (one quotient bit per cycle), 64x64 multiplier built
// from four registered 32x32 partial products, log mantissa and results.
// ----------------------------------------------------------------------------
`default_nettype none
module vml_dp (
    input  wire                        i_clk,
    input  wire                        i_rst_n,
    input  wire vml_pkg::t_cmd         i_cmd,
    input  wire [vml_pkg::N_BITS-1:0]  i_n,
    output vml_pkg::t_sts              o_sts,
    output logic [15:0]                o_base,
    output logic                       o_pp,
    output logic [vml_pkg::LOG_W-1:0]  o_log
);
    localparam int NB = vml_pkg::N_BITS;
    localparam int MW = vml_pkg::MW;
    localparam int DC_W = $clog2(NB);
    localparam int LW = vml_pkg::LOG_W;

    logic [NB-1:0] r_n, r_d, r_p, r_rest;

    // divider
    logic [NB-1:0]   r_dq, r_dr, r_dd;
    logic [DC_W-1:0] r_dcnt;
    logic            r_dbusy, r_ddone;
    logic [NB:0]     w_dtmp;
    logic            w_dge;

    // multiplier
    logic [MW-1:0]     r_ma, r_mb;
    logic [1:0]        r_mcnt;
    logic              r_mbusy, r_pv, r_plast, r_mdone;
    logic [1:0]        r_psh;
    logic [MW-1:0]     r_prod;
    logic [2*MW-1:0]   r_acc;
    logic [MW/2-1:0]   w_ha, w_hb;

    // log
    logic [MW-1:0]                 r_m, r_t1, r_t2;
    logic [vml_pkg::K_W-1:0]       r_k;
    logic [vml_pkg::FRAC_BITS-1:0] r_frac;
    logic [MW-1:0]                 w_sq, w_tot, w_rnd;
    logic [2*NB-1:0]               w_dsq;

    assign w_dtmp = {r_dr, r_dq[NB-1]};
    assign w_dge  = (w_dtmp >= {1'b0, r_dd});
    assign w_dsq  = r_d * r_d;
    assign w_sq   = r_acc[MW+61:62];
    assign w_tot  = r_t1 + r_t2;
    assign w_rnd  = (w_tot + (64'd1 << 39)) >> 40;

    // operand halves for the current partial product
    always_comb begin
        w_ha = r_mcnt[1] ? r_ma[MW-1:MW/2] : r_ma[MW/2-1:0];
        w_hb = r_mcnt[0] ? r_mb[MW-1:MW/2] : r_mb[MW/2-1:0];
    end

    // operand registers and trial state
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_n <= i_n;
            r_d <= NB'(2);
            r_p <= '0;
        end
        if (i_cmd.inc_d)     r_d <= r_d + NB'(1);
        if (i_cmd.set_p_n)   r_p <= r_n;
        if (i_cmd.set_p_d)   r_p <= r_d;
        if (i_cmd.rest_init) r_rest <= r_n;
        if (i_cmd.rest_upd)  r_rest <= r_dq;
    end

    // divider
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dbusy <= 1'b0;
            r_ddone <= 1'b0;
        end else begin
            r_ddone <= 1'b0;
            if (i_cmd.div_trial || i_cmd.div_rest) begin
                r_dbusy <= 1'b1;
                r_dcnt  <= '0;
                r_dr    <= '0;
                r_dq    <= i_cmd.div_trial ? r_n : r_rest;
                r_dd    <= i_cmd.div_trial ? r_d : r_p;
            end else if (r_dbusy) begin
                r_dr <= w_dge ? NB'(w_dtmp - {1'b0, r_dd}) : w_dtmp[NB-1:0];
                r_dq <= {r_dq[NB-2:0], w_dge};
                r_dcnt <= r_dcnt + DC_W'(1);
                if (r_dcnt == DC_W'(NB-1)) begin
                    r_dbusy <= 1'b0;
                    r_ddone <= 1'b1;
                end
            end
        end
    end

    // multiplier: partial product one cycle, accumulate the next
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mbusy <= 1'b0;
            r_pv    <= 1'b0;
            r_mdone <= 1'b0;
        end else begin
            r_mdone <= r_pv && r_plast;
            r_pv    <= r_mbusy;
            if (i_cmd.mul_sq || i_cmd.mul_k || i_cmd.mul_f) begin
                r_mbusy <= 1'b1;
                r_mcnt  <= '0;
                r_acc   <= '0;
                r_ma    <= i_cmd.mul_sq ? r_m :
                           i_cmd.mul_k  ? MW'(r_k) : MW'(r_frac);
                r_mb    <= i_cmd.mul_sq ? r_m : vml_pkg::LN2_Q60;
            end else begin
                if (r_mbusy) begin
                    r_prod  <= w_ha * w_hb;
                    r_psh   <= {1'b0, r_mcnt[1] | r_mcnt[0]} +
                               {1'b0, r_mcnt[1] & r_mcnt[0]};
                    r_plast <= (r_mcnt == 2'd3);
                    r_mcnt  <= r_mcnt + 2'd1;
                    if (r_mcnt == 2'd3) r_mbusy <= 1'b0;
                end
                if (r_pv) begin
                    case (r_psh)
                        2'd0:    r_acc <= r_acc + {64'b0, r_prod};
                        2'd1:    r_acc <= r_acc + {32'b0, r_prod, 32'b0};
                        default: r_acc <= r_acc + {r_prod, 64'b0};
                    endcase
                end
            end
        end
    end

    // log2 mantissa, fraction bits and ln terms
    always_ff @(posedge i_clk) begin
        if (i_cmd.norm_init) begin
            r_m    <= {1'b0, r_p, (MW-1-NB)'(0)};
            r_k    <= vml_pkg::K_W'(NB-1);
            r_frac <= '0;
        end
        if (i_cmd.norm_step) begin
            r_m <= {r_m[MW-2:0], 1'b0};
            r_k <= r_k - vml_pkg::K_W'(1);
        end
        if (i_cmd.sq_upd) begin
            r_m    <= w_sq[MW-1] ? {1'b0, w_sq[MW-1:1]} : w_sq;
            r_frac <= {r_frac[vml_pkg::FRAC_BITS-2:0], w_sq[MW-1]};
        end
        if (i_cmd.t1_upd) r_t1 <= r_acc[67:4];
        if (i_cmd.t2_upd) r_t2 <= r_acc[115:52];
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            o_base <= 16'(r_p);
            o_pp   <= i_cmd.pp;
            o_log  <= i_cmd.pp ? w_rnd[LW-1:0] : '0;
        end
    end

    always_comb begin
        o_sts.n_le1    = (i_n <= NB'(1));
        o_sts.sq_gt_n  = (w_dsq > (2*NB)'(r_n));
        o_sts.div_done = r_ddone;
        o_sts.rem_zero = (r_dr == '0);
        o_sts.quot_one = (r_dq == NB'(1));
        o_sts.m_norm   = r_m[MW-2];
        o_sts.mul_done = r_mdone;
    end
endmodule
`default_nettype wire

// File: hdl/vml_ctrl.sv
// ----------------------------------------------------------------------------
// vml_ctrl: controller of the von Mangoldt block
// Sequences trial division, prime power test and the log iterations, and
// owns the input ready and the output valid.
// ----------------------------------------------------------------------------
`default_nettype none
module vml_ctrl (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_in_valid,
    output logic                o_in_ready,
    output logic                o_out_valid,
    input  wire                 i_out_ready,
    input  wire vml_pkg::t_sts  i_sts,
    output vml_pkg::t_cmd       o_cmd
);
    vml_pkg::t_state r_st, n_st;
    logic [vml_pkg::IT_W-1:0] r_it, n_it;
    logic r_ov, n_ov;
    logic r_pp, n_pp;

    assign o_in_ready  = (r_st == vml_pkg::S_IDLE);
    assign o_out_valid = r_ov;

    // next state and commands
    always_comb begin
        n_st  = r_st;
        n_it  = r_it;
        n_pp  = r_pp;
        n_ov  = r_ov && !i_out_ready;
        o_cmd = '0;
        o_cmd.pp = r_pp;
        case (r_st)
            vml_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_pp = 1'b0;
                    n_st = i_sts.n_le1 ? vml_pkg::S_DONE : vml_pkg::S_CHK;
                end
            end
            vml_pkg::S_CHK: begin
                if (i_sts.sq_gt_n) begin
                    o_cmd.set_p_n   = 1'b1;
                    o_cmd.rest_init = 1'b1;
                    n_st = vml_pkg::S_RDIV;
                end else begin
                    o_cmd.div_trial = 1'b1;
                    n_st = vml_pkg::S_TDIV;
                end
            end
            vml_pkg::S_TDIV: begin
                if (i_sts.div_done) begin
                    if (i_sts.rem_zero) begin
                        o_cmd.set_p_d   = 1'b1;
                        o_cmd.rest_init = 1'b1;
                        n_st = vml_pkg::S_RDIV;
                    end else begin
                        o_cmd.inc_d = 1'b1;
                        n_st = vml_pkg::S_CHK;
                    end
                end
            end
            vml_pkg::S_RDIV: begin
                o_cmd.div_rest = 1'b1;
                n_st = vml_pkg::S_RWAIT;
            end
            vml_pkg::S_RWAIT: begin
                if (i_sts.div_done) begin
                    if (!i_sts.rem_zero) begin
                        n_st = vml_pkg::S_DONE;
                    end else if (i_sts.quot_one) begin
                        n_pp = 1'b1;
                        o_cmd.norm_init = 1'b1;
                        n_st = vml_pkg::S_NORM;
                    end else begin
                        o_cmd.rest_upd = 1'b1;
                        n_st = vml_pkg::S_RDIV;
                    end
                end
            end
            vml_pkg::S_NORM: begin
                if (i_sts.m_norm) begin
                    n_it = '0;
                    n_st = vml_pkg::S_SQ;
                end else begin
                    o_cmd.norm_step = 1'b1;
                end
            end
            vml_pkg::S_SQ: begin
                o_cmd.mul_sq = 1'b1;
                n_st = vml_pkg::S_SQW;
            end
            vml_pkg::S_SQW: begin
                if (i_sts.mul_done) begin
                    o_cmd.sq_upd = 1'b1;
                    n_it = r_it + vml_pkg::IT_W'(1);
                    n_st = (r_it == vml_pkg::IT_W'(vml_pkg::FRAC_BITS-1)) ?
                           vml_pkg::S_KMUL : vml_pkg::S_SQ;
                end
            end
            vml_pkg::S_KMUL: begin
                o_cmd.mul_k = 1'b1;
                n_st = vml_pkg::S_KW;
            end
            vml_pkg::S_KW: begin
                if (i_sts.mul_done) begin
                    o_cmd.t1_upd = 1'b1;
                    n_st = vml_pkg::S_FMUL;
                end
            end
            vml_pkg::S_FMUL: begin
                o_cmd.mul_f = 1'b1;
                n_st = vml_pkg::S_FW;
            end
            vml_pkg::S_FW: begin
                if (i_sts.mul_done) begin
                    o_cmd.t2_upd = 1'b1;
                    n_st = vml_pkg::S_DONE;
                end
            end
            vml_pkg::S_DONE: begin
                // wait for the result register to free up
                if (!r_ov || i_out_ready) begin
                    o_cmd.finish = 1'b1;
                    n_ov = 1'b1;
                    n_st = vml_pkg::S_IDLE;
                end
            end
            default: n_st = vml_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= vml_pkg::S_IDLE;
            r_ov <= 1'b0;
            r_it <= '0;
            r_pp <= 1'b0;
        end else begin
            r_st <= n_st;
            r_ov <= n_ov;
            r_it <= n_it;
            r_pp <= n_pp;
        end
    end
endmodule
`default_nettype wire

// File: hdl/von_mangoldt_lambda.sv
// ----------------------------------------------------------------------------
// von_mangoldt_lambda: von Mangoldt function of a 16-bit unsigned integer
// Top level: controller, datapath and the two valid/ready channels.
// ----------------------------------------------------------------------------
// One item at a time. Trial division runs candidates 2, 3, ... while
// d*d <= n, each candidate taking one pass through the bit-serial divider,
// so a large prime costs the most. Dividing out the factor costs one
// division per power. A prime power then normalizes its mantissa and runs
// 50 multiplies (48 squarings in the four-step 64x64 multiplier plus two
// ln 2 products). A finished result sits in an output register so the
// next item is taken while it waits to be read.
`default_nettype none
module von_mangoldt_lambda (
    input  wire        i_clk,
    input  wire        i_rst_n,
    vml_in_if.sink     i_in,
    vml_out_if.source  o_out
);
    vml_pkg::t_cmd w_cmd;
    vml_pkg::t_sts w_sts;

    vml_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd)
    );

    vml_dp u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (w_cmd),
        .i_n     (i_in.n),
        .o_sts   (w_sts),
        .o_base  (o_out.base),
        .o_pp    (o_out.is_prime_power),
        .o_log   (o_out.log_value)
    );
endmodule
`default_nettype wire

// File: tb/sv/von_mangoldt_lambda_tb.sv
// ----------------------------------------------------------------------------
// von_mangoldt_lambda_tb: self-checking bench for the von Mangoldt block
// Drives integers over the input channel, predicts base, prime-power flag
// and ln(base) in Q5.16, and checks each output beat against the oldest
// prediction. Both channels idle at random in the first two of three phases.
// ----------------------------------------------------------------------------
`default_nettype none
module von_mangoldt_lambda_tb;
    localparam int LW = vml_pkg::LOG_W;

    typedef struct packed {
        logic [15:0]   base;
        logic          is_pp;
        logic [LW-1:0] ln_val;
    } t_lambda;

    localparam logic [63:0] LN2_CONST = 64'h0B17217F7D1CF79B;
    localparam int          CYCLE_LIMIT = 20000000;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    int   err_cnt = 0;
    int   cyc = 0;
    int   src_idle = 0;
    int   snk_idle = 0;

    vml_in_if  in_ch ();
    vml_out_if out_ch ();

    von_mangoldt_lambda dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    task automatic report_mismatch(input string what);
        $display("MISMATCH at cycle %0d: %s", cyc, what);
        err_cnt++;
    endtask

    // (a * b) >> s, 128-bit product
    function automatic logic [63:0] mul_shift(input logic [63:0] a, input logic [63:0] b,
                                              input int s);
        logic [127:0] prod;
        prod = {64'd0, a} * {64'd0, b};
        return 64'(prod >> s);
    endfunction

    // ln(p) in Q5.16 via log2 by squaring
    function automatic logic [63:0] ln_fixed(input logic [63:0] p);
        int          k;
        logic [63:0] mant, frac, sum;
        k = 0;
        while (k < 63 && (p >> (k + 1)) != 0) k++;
        if (k > 62) k = 62;
        mant = p << (62 - k);
        frac = 0;
        for (int i = 0; i < vml_pkg::FRAC_BITS; i++) begin
            mant = mul_shift(mant, mant, 62);
            frac = frac << 1;
            if (mant[63]) begin
                mant = mant >> 1;
                frac[0] = 1'b1;
            end
        end
        sum = mul_shift(64'(k), LN2_CONST, 4) + mul_shift(frac, LN2_CONST, 52);
        return (sum + (64'd1 << 39)) >> 40;
    endfunction

    function automatic t_lambda lambda_of(input logic [15:0] n);
        t_lambda r;
        int      p, rest;
        r = '0;
        if (n <= 1) return r;
        p = 0;
        for (int d = 2; d * d <= n; d++) begin
            if (n % d == 0) begin
                p = d;
                break;
            end
        end
        if (p == 0) p = n;
        rest = n;
        while (rest % p == 0) rest = rest / p;
        r.base  = 16'(p);
        r.is_pp = (rest == 1);
        r.ln_val = r.is_pp ? LW'(ln_fixed(64'(p))) : '0;
        return r;
    endfunction

    class lambda_board;
        t_lambda pending[$];

        function void note_input(logic [15:0] n);
            pending.push_back(lambda_of(n));
        endfunction

        task check_result(t_lambda got);
            t_lambda want;
            if (pending.size() == 0) begin
                report_mismatch($sformatf("unexpected beat base=%0d", got.base));
                return;
            end
            want = pending.pop_front();
            if (got.base !== want.base)
                report_mismatch($sformatf("base %0d, want %0d", got.base, want.base));
            if (got.is_pp !== want.is_pp)
                report_mismatch($sformatf("prime power %0b, want %0b (base %0d)",
                                          got.is_pp, want.is_pp, want.base));
            if (got.ln_val !== want.ln_val)
                report_mismatch($sformatf("log %0h, want %0h (base %0d)",
                                          got.ln_val, want.ln_val, want.base));
        endtask
    endclass

    lambda_board board = new();

    // cycle count and timeout
    always @(posedge i_clk) begin
        cyc <= cyc + 1;
        if (cyc > CYCLE_LIMIT) begin
            $display("Timeout at cycle %0d", cyc);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // sample both channels at the rising edge
    always @(posedge i_clk) begin
        if (i_rst_n && in_ch.valid && in_ch.ready)
            board.note_input(in_ch.n);
        if (i_rst_n && out_ch.valid && out_ch.ready)
            board.check_result({out_ch.base, out_ch.is_prime_power, out_ch.log_value});
    end

    // receiver: random stalls on the falling edge, held low in reset
    always @(negedge i_clk) begin
        out_ch.ready <= i_rst_n && ($urandom_range(99) >= snk_idle);
    end

    // called at a falling edge; ready is stable until the next rising edge
    task automatic send_n(input logic [15:0] n);
        while ($urandom_range(99) < src_idle) begin
            in_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.n     <= n;
        while (!in_ch.ready) @(negedge i_clk);
        @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // mostly small values keep trial division short
    function automatic logic [15:0] rand_n();
        int pick, b, e, v;
        pick = $urandom_range(99);
        if (pick < 35) return 16'($urandom_range(255));
        if (pick < 60) begin
            b = $urandom_range(2, 60);
            e = $urandom_range(1, 6);
            v = b;
            for (int i = 1; i < e && v * b < 65536; i++) v = v * b;
            return 16'(v);
        end
        if (pick < 90) return 16'($urandom_range(4095));
        return 16'($urandom);
    endfunction

    initial begin
        logic [15:0] directed[$];
        directed = '{16'd0, 16'd1, 16'd2, 16'd3, 16'd4, 16'd6, 16'd9,
            16'd12, 16'd25, 16'd32768, 16'd65535, 16'd65521, 16'd65533,
            16'd65534, 16'd59049, 16'd16807, 16'd65025, 16'd32767, 16'd21845,
            16'd43690, 16'd255, 16'd256, 16'd1024};
        in_ch.valid  = 1'b0;
        in_ch.n      = '0;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        src_idle = 6;
        snk_idle = 53;
        foreach (directed[i]) send_n(directed[i]);
        for (int i = 0; i < 90; i++) send_n(rand_n());
        src_idle = 53;
        snk_idle = 6;
        for (int i = 0; i < 90; i++) send_n(rand_n());
        src_idle = 0;
        snk_idle = 0;
        for (int i = 0; i < 90; i++) send_n(rand_n());
        in_ch.valid <= 1'b0;

        while (board.pending.size() != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
        if (err_cnt == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule
`default_nettype wire

// File: filelist.f
hdl/vml_pkg.sv
hdl/vml_if.sv
hdl/vml_dp.sv
hdl/vml_ctrl.sv
hdl/von_mangoldt_lambda.sv
tb/sv/von_mangoldt_lambda_tb.sv
